@@ sv/lsp2c_pkg.sv @@
// ----------------------------------------------------------------------------
// lsp2c_pkg
// Shared constants, types and the arctangent step table of the lidar scan
// polar-to-Cartesian converter.
// ----------------------------------------------------------------------------
package lsp2c_pkg;

  localparam int ROTATION_STEPS = 16;
  localparam int MAX_SAMPLES    = 4096;
  localparam int TABLE_LEN      = 24;
  localparam int ROT_STEPS      = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;
  localparam int STEP_W         = (ROT_STEPS > 1) ? $clog2(ROT_STEPS) : 1;

  localparam int IDX_W   = 12;
  localparam int WIN_W   = 13;
  localparam int ANG_W   = 32;
  localparam int RANGE_W = 16;
  localparam int POS_W   = 17;
  localparam int XY_W    = 20;
  localparam int Z_W     = 33;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [RANGE_W-1:0] INV_GAIN = 16'd39797;

  localparam logic [2:0] REG_ANGLE_START = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
  localparam logic [2:0] REG_LEFT_BEGIN  = 3'd2;
  localparam logic [2:0] REG_LEFT_END    = 3'd3;
  localparam logic [2:0] REG_RIGHT_BEGIN = 3'd4;
  localparam logic [2:0] REG_RIGHT_END   = 3'd5;

  typedef struct packed {
    logic [ANG_W-1:0] angle_start;
    logic [ANG_W-1:0] angle_step;
    logic [WIN_W-1:0] left_begin;
    logic [WIN_W-1:0] left_end;
    logic [WIN_W-1:0] right_begin;
    logic [WIN_W-1:0] right_end;
  } cfg_t;

  typedef struct packed {
    logic              load_in;
    logic              mul;
    logic              prep;
    logic              rot;
    logic [STEP_W-1:0] step;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } sts_t;

  function automatic logic [29:0] atan_step(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/lidar_scan_polar_to_cartesian_core.sv @@
// ----------------------------------------------------------------------------
// lidar_scan_polar_to_cartesian_core
// Converts lidar range samples inside two index windows into x/y points.
//
//   channel  dir  handshake             payload
//   in       in   in_valid_i/in_stall_o range_value_i, scan_last_i
//   out      out  out_valid_o/out_stall_i x_pos_o, y_pos_o, beam_index_o
//   cfg      in   APB psel/penable      paddr, pwdata, prdata
//
// A sample outside both windows leaves after the multiply and window test; a
// sample inside also runs ROT_STEPS steps through one shared CORDIC stage.
// One request is in flight at a time; a finished point waits in the output
// register while the next request is accepted and worked on.
// Reset clears the sample counter, state machine and output valid.
// ----------------------------------------------------------------------------
module lidar_scan_polar_to_cartesian_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lsp2c_pkg::RANGE_W-1:0]       range_value_i,
  input  logic                                scan_last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lsp2c_pkg::POS_W-1:0]  x_pos_o,
  output logic signed [lsp2c_pkg::POS_W-1:0]  y_pos_o,
  output logic [lsp2c_pkg::IDX_W-1:0]         beam_index_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsp2c_pkg::ADDR_W-1:0]        paddr,
  input  logic [lsp2c_pkg::DATA_W-1:0]        pwdata,
  output logic [lsp2c_pkg::DATA_W-1:0]        prdata,
  output logic                                pready
);

  lsp2c_pkg::cfg_t cfg;
  lsp2c_pkg::cmd_t cmd;
  lsp2c_pkg::sts_t sts;

  lsp2c_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lsp2c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lsp2c_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .range_value_i (range_value_i),
    .scan_last_i   (scan_last_i),
    .x_pos_o       (x_pos_o),
    .y_pos_o       (y_pos_o),
    .beam_index_o  (beam_index_o)
  );

endmodule

@@ sv/lsp2c_cfg.sv @@
// ----------------------------------------------------------------------------
// lsp2c_cfg
// APB-style register file holding the angle and window settings.
// ----------------------------------------------------------------------------
module lsp2c_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsp2c_pkg::ADDR_W-1:0] paddr,
  input  logic [lsp2c_pkg::DATA_W-1:0] pwdata,
  output logic [lsp2c_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output lsp2c_pkg::cfg_t              cfg_o
);

  lsp2c_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]      reg_sel;
  logic            wr_en;

  assign reg_sel = paddr[lsp2c_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        lsp2c_pkg::REG_ANGLE_START: cfg_d.angle_start = pwdata;
        lsp2c_pkg::REG_ANGLE_STEP:  cfg_d.angle_step  = pwdata;
        lsp2c_pkg::REG_LEFT_BEGIN:  cfg_d.left_begin  = pwdata[lsp2c_pkg::WIN_W-1:0];
        lsp2c_pkg::REG_LEFT_END:    cfg_d.left_end    = pwdata[lsp2c_pkg::WIN_W-1:0];
        lsp2c_pkg::REG_RIGHT_BEGIN: cfg_d.right_begin = pwdata[lsp2c_pkg::WIN_W-1:0];
        lsp2c_pkg::REG_RIGHT_END:   cfg_d.right_end   = pwdata[lsp2c_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lsp2c_pkg::REG_ANGLE_START: prdata = cfg_q.angle_start;
      lsp2c_pkg::REG_ANGLE_STEP:  prdata = cfg_q.angle_step;
      lsp2c_pkg::REG_LEFT_BEGIN:  prdata = 32'(cfg_q.left_begin);
      lsp2c_pkg::REG_LEFT_END:    prdata = 32'(cfg_q.left_end);
      lsp2c_pkg::REG_RIGHT_BEGIN: prdata = 32'(cfg_q.right_begin);
      lsp2c_pkg::REG_RIGHT_END:   prdata = 32'(cfg_q.right_end);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_start <= 32'd2147483648;
      cfg_q.angle_step  <= 32'd8388608;
      cfg_q.left_begin  <= 13'd0;
      cfg_q.left_end    <= 13'd127;
      cfg_q.right_begin <= 13'd378;
      cfg_q.right_end   <= 13'd505;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ sv/lsp2c_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsp2c_ctrl
// Sequencer: request intake, multiply, CORDIC setup, rotation steps and
// hand-off to the output register.
// ----------------------------------------------------------------------------
module lsp2c_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  lsp2c_pkg::sts_t sts_i,
  output lsp2c_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_ROT  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [lsp2c_pkg::STEP_W-1:0] step_q, step_d;
  logic                         out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_PREP;
      end
      S_PREP: begin
        if (sts_i.hit) begin
          cmd_o.prep = 1'b1;
          step_d     = '0;
          state_d    = S_ROT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ROT: begin
        cmd_o.rot  = 1'b1;
        cmd_o.step = step_q;
        if (step_q == lsp2c_pkg::STEP_W'(lsp2c_pkg::ROT_STEPS - 1)) begin
          state_d = S_OUT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ sv/lsp2c_dp.sv @@
// ----------------------------------------------------------------------------
// lsp2c_dp
// Datapath: sample counter, beam angle, window test, gain-corrected
// CORDIC rotation and the result register.
// ----------------------------------------------------------------------------
module lsp2c_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsp2c_pkg::cfg_t               cfg_i,
  input  lsp2c_pkg::cmd_t               cmd_i,
  output lsp2c_pkg::sts_t               sts_o,
  input  logic [lsp2c_pkg::RANGE_W-1:0] range_value_i,
  input  logic                          scan_last_i,
  output logic signed [lsp2c_pkg::POS_W-1:0] x_pos_o,
  output logic signed [lsp2c_pkg::POS_W-1:0] y_pos_o,
  output logic [lsp2c_pkg::IDX_W-1:0]   beam_index_o
);

  logic [lsp2c_pkg::IDX_W-1:0]   count_q;
  logic [lsp2c_pkg::IDX_W:0]     count_inc;
  logic [lsp2c_pkg::IDX_W-1:0]   idx_q;
  logic [lsp2c_pkg::RANGE_W-1:0] range_q;
  logic [lsp2c_pkg::ANG_W-1:0]   aprod_q;
  logic [2*lsp2c_pkg::RANGE_W-1:0] rprod_q;
  logic                          hit_q;
  logic [lsp2c_pkg::WIN_W-1:0]   idx_w;
  logic                          hit_d;

  logic [lsp2c_pkg::ANG_W-1:0]   angle;
  logic                          fold;
  logic [lsp2c_pkg::ANG_W-1:0]   angle_f;
  logic [2*lsp2c_pkg::RANGE_W+1:0] rnd;
  logic signed [lsp2c_pkg::XY_W-1:0] x_init;

  logic signed [lsp2c_pkg::XY_W-1:0] x_q, y_q;
  logic signed [lsp2c_pkg::Z_W-1:0]  z_q;
  logic signed [lsp2c_pkg::XY_W-1:0] dx, dy;
  logic signed [lsp2c_pkg::Z_W-1:0]  at;

  logic signed [lsp2c_pkg::POS_W-1:0] x_pos_q, y_pos_q;
  logic [lsp2c_pkg::IDX_W-1:0]        beam_index_q;

  function automatic logic [lsp2c_pkg::POS_W-1:0] finish(
    input logic signed [lsp2c_pkg::XY_W-1:0] v
  );
    logic signed [lsp2c_pkg::XY_W-1:0] r;
    logic [lsp2c_pkg::POS_W-1:0]       o;
    r = (v + 20'sd1) >>> 1;
    if (r > 20'sd65535) begin
      o = 17'h0FFFF;
    end else if (r < -20'sd65536) begin
      o = 17'h10000;
    end else begin
      o = r[lsp2c_pkg::POS_W-1:0];
    end
    return o;
  endfunction

  assign sts_o.hit    = hit_q;
  assign x_pos_o      = x_pos_q;
  assign y_pos_o      = y_pos_q;
  assign beam_index_o = beam_index_q;

  assign count_inc = {1'b0, count_q} + 1'b1;
  assign idx_w     = {1'b0, idx_q};
  assign hit_d     = (idx_w >= cfg_i.left_begin  && idx_w < cfg_i.left_end) ||
                     (idx_w >= cfg_i.right_begin && idx_w < cfg_i.right_end);

  // angle fold into [-1/4, 1/4) turn, x negated on a half-turn fold
  assign angle   = cfg_i.angle_start + aprod_q;
  assign fold    = angle[31] ^ angle[30];
  assign angle_f = {angle[31] ^ fold, angle[30:0]};
  assign rnd     = {1'b0, rprod_q, 1'b0} + 34'd32768;
  assign x_init  = $signed({3'b000, rnd[32:16]});

  assign dx = y_q >>> cmd_i.step;
  assign dy = x_q >>> cmd_i.step;
  assign at = $signed({3'b000, lsp2c_pkg::atan_step(5'(cmd_i.step))});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load_in) begin
      if (scan_last_i || count_inc >= 13'(lsp2c_pkg::MAX_SAMPLES)) begin
        count_q <= '0;
      end else begin
        count_q <= count_inc[lsp2c_pkg::IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      idx_q   <= count_q;
      range_q <= range_value_i;
    end
    if (cmd_i.mul) begin
      aprod_q <= 32'(idx_q * cfg_i.angle_step);
      rprod_q <= range_q * lsp2c_pkg::INV_GAIN;
      hit_q   <= hit_d;
    end
    if (cmd_i.prep) begin
      x_q <= fold ? -x_init : x_init;
      y_q <= '0;
      z_q <= $signed({angle_f[31], angle_f});
    end else if (cmd_i.rot) begin
      if (!z_q[lsp2c_pkg::Z_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
    if (cmd_i.load_out) begin
      x_pos_q      <= finish(x_q);
      y_pos_q      <= finish(y_q);
      beam_index_q <= idx_q;
    end
  end

endmodule

@@ sv/lsp2c_chk.sv @@
// ----------------------------------------------------------------------------
// lsp2c_chk
// Port-level checks for the polar-to-Cartesian core, bound to the top level.
// ----------------------------------------------------------------------------
module lsp2c_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [lsp2c_pkg::POS_W-1:0] x_pos_o,
  input logic signed [lsp2c_pkg::POS_W-1:0] y_pos_o,
  input logic [lsp2c_pkg::IDX_W-1:0]        beam_index_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(x_pos_o) &&
      $stable(y_pos_o) && $stable(beam_index_o))
    else $error("stalled result changed");

  // one request in flight: busy right after intake
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("intake not blocked after request");

  // a new result is only produced while a request is being worked on
  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without request in flight");

  // a miss or a hit still blocks intake in the window-test state after the multiply
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 in_stall_o)
    else $error("request finished too early");

endmodule

bind lidar_scan_polar_to_cartesian_core lsp2c_chk u_lsp2c_chk (.*);
